### design/psd_pkg.sv
// shared types and constants of the priority slot dispatcher
`timescale 1ns / 1ps
`default_nettype none

package psd_pkg;

  // fixed field widths of the stream words
  localparam int unsigned JobIdW    = 16;
  localparam int unsigned ClassW    = 2;
  localparam int unsigned SlotNumW  = 4;
  localparam int unsigned SlotIdxW  = 3;
  localparam int unsigned StatusW   = 3;
  localparam int unsigned NumClasses = 3;

  // padded word widths
  localparam int unsigned InDataW  = 24;
  localparam int unsigned OutDataW = 40;

  // least urgent class, also taken for a class code of zero
  localparam logic [ClassW-1:0] ClassLowest = 2'd3;
  localparam logic [ClassW-1:0] ClassNone   = 2'd0;

  // request kinds carried in tuser
  localparam logic ModeArrive  = 1'b0;
  localparam logic ModeRelease = 1'b1;

  typedef enum logic [StatusW-1:0] {
    ST_PLACED   = 3'd0,
    ST_QUEUED   = 3'd1,
    ST_DROPPED  = 3'd2,
    ST_REFILLED = 3'd3,
    ST_IDLE     = 3'd4,
    ST_BAD_SLOT = 3'd5,
    ST_EMPTY    = 3'd6
  } status_e;

  // one request word
  typedef struct packed {
    logic                mode;
    logic [JobIdW-1:0]   job_id;
    logic [ClassW-1:0]   job_class;
    logic [SlotNumW-1:0] slot_number;
  } request_t;

  // one result word
  typedef struct packed {
    status_e             status;
    logic [SlotIdxW-1:0] slot_index;
    logic [JobIdW-1:0]   placed_id;
    logic [ClassW-1:0]   placed_class;
    logic [JobIdW-1:0]   finished_id;
    logic [ClassW-1:0]   finished_class;
  } result_t;

endpackage

`default_nettype wire

### design/psd_ram.sv
// generic single write port ram with registered read
`timescale 1ns / 1ps
`default_nettype none

module psd_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read, old data on a collision
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

### design/priority_slot_dispatcher.sv
// top level of the priority slot dispatcher: request register, dispatch logic, result register
//
// usage
//   requests enter on the s_axis channel, one word per accept; tuser is the kind
//   (0 a job arrives, 1 a slot finishes), tdata holds job id, class and slot number
//   every request gives exactly one result word on the m_axis channel; tuser holds
//   the status code, tdata the slot index and the placed and finished job fields
//   an accepted request waits in the request register until dispatch, and its result
//   word is then held in the result register; the dispatch decision sits between the
//   request register and the result register
//   throughput is one word per cycle while m_axis_tready does not stall; it is set by
//   the combinational dispatch step, with the queue heads read from per-class rams
//   at the next head pointer, and a bypass for a word written to the slot being read
//   a stalled m_axis_tready holds the result register; one more request is taken
//   into the request register, then s_axis_tready drops until the result is taken
//   reset frees every slot and empties the three class queues at once; the queue
//   storage itself is not cleared and needs no clearing pass
`timescale 1ns / 1ps
`default_nettype none

module priority_slot_dispatcher #(
  parameter int unsigned SLOT_COUNT        = 5,
  parameter int unsigned CLASS_QUEUE_DEPTH = 16,
  parameter int unsigned JOB_ID_BITS       = 16
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  // request channel
  input  wire logic                        s_axis_tvalid,
  output logic                             s_axis_tready,
  // tdata: job_id[15:0], job_class[17:16], slot_number[21:18], zero pad
  input  wire logic [psd_pkg::InDataW-1:0] s_axis_tdata,
  // tuser: mode[0]
  input  wire logic [0:0]                  s_axis_tuser,
  // result channel
  output logic                             m_axis_tvalid,
  input  wire logic                        m_axis_tready,
  // tdata: slot_index[2:0], placed_id[18:3], placed_class[20:19],
  //        finished_id[36:21], finished_class[38:37], zero pad
  output logic [psd_pkg::OutDataW-1:0]     m_axis_tdata,
  // tuser: status[2:0]
  output logic [psd_pkg::StatusW-1:0]      m_axis_tuser
);

  import psd_pkg::*;

  localparam int unsigned IdW     = (JOB_ID_BITS < JobIdW) ? JOB_ID_BITS : JobIdW;
  localparam int unsigned SlotW   = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int unsigned PtrW    = $clog2(CLASS_QUEUE_DEPTH);
  localparam int unsigned CntW    = $clog2(CLASS_QUEUE_DEPTH + 1);
  localparam logic [SlotNumW:0] SlotCountL = (SlotNumW + 1)'(SLOT_COUNT);
  localparam logic [PtrW-1:0]   PtrLast    = PtrW'(CLASS_QUEUE_DEPTH - 1);
  localparam logic [CntW-1:0]   CntFull    = CntW'(CLASS_QUEUE_DEPTH);

  // request register
  logic     in_valid_q;
  request_t in_q;
  // result register
  logic     out_valid_q;
  result_t  out_q, out_d;

  // slot state
  logic            busy_q  [SLOT_COUNT];
  logic            busy_d  [SLOT_COUNT];
  logic [IdW-1:0]  sid_q   [SLOT_COUNT];
  logic [IdW-1:0]  sid_d   [SLOT_COUNT];
  logic [ClassW-1:0] scls_q [SLOT_COUNT];
  logic [ClassW-1:0] scls_d [SLOT_COUNT];

  // queue pointers and counts
  logic [PtrW-1:0] head_q [NumClasses];
  logic [PtrW-1:0] head_d [NumClasses];
  logic [PtrW-1:0] tail_q [NumClasses];
  logic [PtrW-1:0] tail_d [NumClasses];
  logic [CntW-1:0] fill_q [NumClasses];
  logic [CntW-1:0] fill_d [NumClasses];

  // queue ram ports and head bypass
  logic            q_we    [NumClasses];
  logic [PtrW-1:0] q_waddr;
  logic [IdW-1:0]  q_wdata;
  logic [IdW-1:0]  q_rdata [NumClasses];
  logic [IdW-1:0]  q_head  [NumClasses];
  logic            byp_q   [NumClasses];
  logic [IdW-1:0]  byp_data_q;

  logic fire;

  // handshake
  assign fire          = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || fire;

  // request register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_q.mode        <= s_axis_tuser[0];
      in_q.job_id      <= s_axis_tdata[15:0];
      in_q.job_class   <= s_axis_tdata[17:16];
      in_q.slot_number <= s_axis_tdata[21:18];
    end
  end

  // class queue rams, read at the next head so the head word is ready in time
  for (genvar g = 0; g < NumClasses; g++) begin : g_queue
    psd_ram #(
      .WIDTH (IdW),
      .DEPTH (CLASS_QUEUE_DEPTH)
    ) u_ram (
      .clk_i   (clk_i),
      .we_i    (q_we[g]),
      .waddr_i (q_waddr),
      .wdata_i (q_wdata),
      .raddr_i (head_d[g]),
      .rdata_o (q_rdata[g])
    );

    assign q_head[g] = byp_q[g] ? byp_data_q : q_rdata[g];

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        byp_q[g] <= 1'b0;
      end else begin
        byp_q[g] <= q_we[g] && (q_waddr == head_d[g]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    byp_data_q <= q_wdata;
  end

  // dispatch decision
  always_comb begin
    logic [ClassW-1:0] cls;
    logic [1:0]        cidx;
    logic              free_found;
    logic [SlotW-1:0]  free_idx;
    logic              any_wait;
    logic [1:0]        best;
    logic [SlotW-1:0]  rel;

    for (int s = 0; s < SLOT_COUNT; s++) begin
      busy_d[s] = busy_q[s];
      sid_d[s]  = sid_q[s];
      scls_d[s] = scls_q[s];
    end
    for (int c = 0; c < NumClasses; c++) begin
      head_d[c] = head_q[c];
      tail_d[c] = tail_q[c];
      fill_d[c] = fill_q[c];
      q_we[c]   = 1'b0;
    end
    out_d   = '0;
    q_wdata = in_q.job_id[IdW-1:0];

    // class zero counts as the least urgent class
    cls  = (in_q.job_class == ClassNone) ? ClassLowest : in_q.job_class;
    cidx = cls - 2'd1;
    q_waddr = tail_q[cidx];

    // lowest free slot
    free_found = 1'b0;
    free_idx   = '0;
    for (int s = 0; s < SLOT_COUNT; s++) begin
      if (!free_found && !busy_q[s]) begin
        free_found = 1'b1;
        free_idx   = SlotW'(s);
      end
    end

    // most urgent non-empty class
    any_wait = 1'b0;
    best     = '0;
    for (int c = NumClasses - 1; c >= 0; c--) begin
      if (fill_q[c] != '0) begin
        any_wait = 1'b1;
        best     = 2'(c);
      end
    end

    rel = SlotW'(in_q.slot_number - 4'd1);

    if (in_q.mode == ModeArrive) begin
      if (free_found) begin
        busy_d[free_idx]   = 1'b1;
        sid_d[free_idx]    = in_q.job_id[IdW-1:0];
        scls_d[free_idx]   = cls;
        out_d.status       = ST_PLACED;
        out_d.slot_index   = SlotIdxW'(free_idx);
        out_d.placed_id    = JobIdW'(in_q.job_id[IdW-1:0]);
        out_d.placed_class = cls;
      end else if (fill_q[cidx] == CntFull) begin
        out_d.status = ST_DROPPED;
      end else begin
        q_we[cidx]   = fire;
        tail_d[cidx] = (tail_q[cidx] == PtrLast) ? '0 : tail_q[cidx] + 1'b1;
        fill_d[cidx] = fill_q[cidx] + 1'b1;
        out_d.status = ST_QUEUED;
      end
    end else begin
      if (in_q.slot_number == '0 || {1'b0, in_q.slot_number} > SlotCountL) begin
        out_d.status = ST_BAD_SLOT;
      end else begin
        out_d.slot_index = SlotIdxW'(rel);
        if (!busy_q[rel]) begin
          out_d.status = ST_EMPTY;
        end else begin
          out_d.finished_id    = JobIdW'(sid_q[rel]);
          out_d.finished_class = scls_q[rel];
          if (any_wait) begin
            sid_d[rel]         = q_head[best];
            scls_d[rel]        = best + 2'd1;
            head_d[best]       = (head_q[best] == PtrLast) ? '0 : head_q[best] + 1'b1;
            fill_d[best]       = fill_q[best] - 1'b1;
            out_d.status       = ST_REFILLED;
            out_d.placed_id    = JobIdW'(q_head[best]);
            out_d.placed_class = best + 2'd1;
          end else begin
            busy_d[rel]  = 1'b0;
            out_d.status = ST_IDLE;
          end
        end
      end
    end

    // state moves only with a dispatched word
    if (!fire) begin
      for (int s = 0; s < SLOT_COUNT; s++) begin
        busy_d[s] = busy_q[s];
        sid_d[s]  = sid_q[s];
        scls_d[s] = scls_q[s];
      end
      for (int c = 0; c < NumClasses; c++) begin
        head_d[c] = head_q[c];
        tail_d[c] = tail_q[c];
        fill_d[c] = fill_q[c];
      end
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < SLOT_COUNT; s++) begin
        busy_q[s] <= 1'b0;
      end
      for (int c = 0; c < NumClasses; c++) begin
        head_q[c] <= '0;
        tail_q[c] <= '0;
        fill_q[c] <= '0;
      end
    end else begin
      for (int s = 0; s < SLOT_COUNT; s++) begin
        busy_q[s] <= busy_d[s];
      end
      for (int c = 0; c < NumClasses; c++) begin
        head_q[c] <= head_d[c];
        tail_q[c] <= tail_d[c];
        fill_q[c] <= fill_d[c];
      end
    end
  end

  // slot payload
  always_ff @(posedge clk_i) begin
    for (int s = 0; s < SLOT_COUNT; s++) begin
      sid_q[s]  <= sid_d[s];
      scls_q[s] <= scls_d[s];
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!out_valid_q || m_axis_tready) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_q <= out_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_q.status;
  assign m_axis_tdata  = {1'b0, out_q.finished_class, out_q.finished_id,
                          out_q.placed_class, out_q.placed_id, out_q.slot_index};

  // checks
  logic any_overfull;
  logic any_queued;
  logic all_busy;

  always_comb begin
    any_overfull = 1'b0;
    any_queued   = 1'b0;
    for (int c = 0; c < NumClasses; c++) begin
      any_overfull = any_overfull || (fill_q[c] > CntFull);
      any_queued   = any_queued || (fill_q[c] != '0);
    end
    all_busy = 1'b1;
    for (int s = 0; s < SLOT_COUNT; s++) begin
      all_busy = all_busy && busy_q[s];
    end
  end

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !any_overfull)
    else $error("class queue fill count above depth");

  a_wait_all_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    any_queued |-> all_busy)
    else $error("job waiting while a slot is free");

  a_fire_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |=> m_axis_tvalid)
    else $error("dispatched word gave no result");

  a_refill_class: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (m_axis_tuser == ST_REFILLED || m_axis_tuser == ST_PLACED))
      |-> (out_q.placed_class != ClassNone))
    else $error("placed result without a class");

endmodule

`default_nettype wire
